@@ rtl/r30rng_pkg.sv @@
`timescale 1ns / 1ps

package r30rng_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned HALF_W = 16;

    localparam logic [WORD_W-1:0] RESET_WORD = 32'd1946;

    localparam logic [1:0] OP_SEED  = 2'd0;
    localparam logic [1:0] OP_RAW   = 2'd1;
    localparam logic [1:0] OP_MOD   = 2'd2;
    localparam logic [1:0] OP_MOD16 = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic div_step;
        logic out_load;
    } r30rng_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic need_div;
    } r30rng_stat_t;

endpackage

@@ rtl/r30rng_dp.sv @@
`timescale 1ns / 1ps

module r30rng_dp
    import r30rng_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  r30rng_cmd_t         cmd,
    output r30rng_stat_t        stat,
    input  logic [1:0]          s_opcode,
    input  logic [WORD_W-1:0]   s_seed_value,
    input  logic [WORD_W-1:0]   s_bound,
    output logic [WORD_W-1:0]   m_value
);

    logic [WORD_W-1:0] word_reg, word_next;
    logic [WORD_W-1:0] cnt_reg, cnt_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] dvd_reg, dvd_next;
    logic [WORD_W-1:0] dsr_reg, dsr_next;
    logic [WORD_W-1:0] value_reg, value_next;

    logic [WORD_W-1:0] stepped;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   diff;
    logic              bound_nz;
    logic              bound16_nz;

    assign stepped = {word_reg[0], word_reg[WORD_W-1:1]}
                   ^ (word_reg | {word_reg[WORD_W-2:0], word_reg[WORD_W-1]})
                   ^ cnt_reg;

    assign bound_nz   = (s_bound != '0);
    assign bound16_nz = (s_bound[HALF_W-1:0] != '0);

    assign stat.need_div = ((s_opcode == OP_MOD) && bound_nz)
                        || ((s_opcode == OP_MOD16) && bound16_nz);

    // restoring division, one quotient bit a cycle; only the remainder is kept
    assign trial = {rem_reg, dvd_reg[WORD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb begin
        word_next  = word_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        dsr_next   = dsr_reg;
        value_next = value_reg;
        if (cmd.accept) begin
            unique case (s_opcode)
                OP_SEED: begin
                    if (s_seed_value != '0) begin
                        word_next = s_seed_value;
                        cnt_next  = '0;
                        rem_next  = s_seed_value;
                    end else begin
                        word_next = stepped;
                        cnt_next  = cnt_reg + 1'b1;
                        rem_next  = stepped;
                    end
                end
                OP_RAW: begin
                    word_next = stepped;
                    cnt_next  = cnt_reg + 1'b1;
                    rem_next  = stepped;
                end
                OP_MOD: begin
                    if (bound_nz) begin
                        word_next = stepped;
                        cnt_next  = cnt_reg + 1'b1;
                    end
                    rem_next = '0;
                    dvd_next = stepped;
                    dsr_next = s_bound;
                end
                OP_MOD16: begin
                    if (bound16_nz) begin
                        word_next = stepped;
                        cnt_next  = cnt_reg + 1'b1;
                    end
                    rem_next = '0;
                    dvd_next = {{(WORD_W-HALF_W){1'b0}}, stepped[HALF_W-1:0]};
                    dsr_next = {{(WORD_W-HALF_W){1'b0}}, s_bound[HALF_W-1:0]};
                end
                default: begin
                    rem_next = '0;
                end
            endcase
        end else if (cmd.div_step) begin
            rem_next = diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
            dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
        end
        if (cmd.out_load) begin
            value_next = rem_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg <= RESET_WORD;
            cnt_reg  <= '0;
        end else begin
            word_reg <= word_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        dsr_reg   <= dsr_next;
        value_reg <= value_next;
    end

    assign m_value = value_reg;

endmodule

@@ rtl/r30rng_ctrl.sv @@
`timescale 1ns / 1ps

module r30rng_ctrl
    import r30rng_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  r30rng_stat_t  stat,
    output r30rng_cmd_t   cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_PUT  = 2'd2;

    localparam int unsigned ITER_W = $clog2(WORD_W);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(WORD_W - 1);

    logic [1:0]        state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              m_valid_reg, m_valid_next;
    logic              out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        iter_next    = iter_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    iter_next  = '0;
                    state_next = stat.need_div ? ST_DIV : ST_PUT;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                iter_next    = iter_reg + 1'b1;
                if (iter_reg == ITER_LAST) begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            iter_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            iter_reg    <= iter_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

@@ rtl/rule30_counter_random_generator.sv @@
`timescale 1ns / 1ps
// Rule 30 random generator with step counter, 32-bit word.
// Input channel s_*: one request word per handshake (s_opcode, s_seed_value,
// s_bound). Opcode 0 reseeds (zero seed draws instead), 1 draws the raw word,
// 2 draws modulo s_bound, 3 draws the low half modulo the low half of s_bound.
// Output channel m_*: exactly one m_value word per request, in order.
// Reseed, raw draw and zero-bound requests go from acceptance straight to
// the output load; ranged draws first run the bit-serial remainder unit and
// then the output load. The step is taken at acceptance.
// One request is worked at a time; s_ready is high only while the controller
// is idle. The output register holds a finished word, so the next request is
// taken while the receiver stalls; it then waits before its own output load.
// Synchronous active-low reset sets the word to 1946, the counter to zero and
// empties the output register.
module rule30_counter_random_generator
    import r30rng_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_opcode,
    input  logic [WORD_W-1:0]   s_seed_value,
    input  logic [WORD_W-1:0]   s_bound,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [WORD_W-1:0]   m_value
);

    r30rng_cmd_t  cmd;
    r30rng_stat_t stat;

    r30rng_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    r30rng_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_opcode     (s_opcode),
        .s_seed_value (s_seed_value),
        .s_bound      (s_bound),
        .m_value      (m_value)
    );

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while previous one still in work");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("output word overwritten before it was taken");

    a_div_not_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> (!s_ready && !cmd.accept && !cmd.out_load))
        else $error("remainder unit stepping outside its phase");
`endif

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import r30rng_pkg::*;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_opcode = OP_RAW;
    logic [WORD_W-1:0] s_seed_value = '0;
    logic [WORD_W-1:0] s_bound = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [WORD_W-1:0] m_value;

    // predictor state
    logic [WORD_W-1:0] gen_word = RESET_WORD;
    logic [WORD_W-1:0] gen_count = '0;

    logic [WORD_W-1:0] pending_values[$];
    int unsigned       err_count = 0;
    bit                src_idle_on = 1'b1;
    bit                sink_idle_on = 1'b1;
    int                sink_hold = 0;

    rule30_counter_random_generator dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_seed_value (s_seed_value),
        .s_bound      (s_bound),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [WORD_W-1:0] rule30_advance();
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] nxt;
        w = gen_word;
        nxt = {w[0], w[WORD_W-1:1]} ^ (w | {w[WORD_W-2:0], w[WORD_W-1]});
        nxt = nxt ^ gen_count;
        gen_count = gen_count + 1;
        gen_word = nxt;
        return nxt;
    endfunction

    function automatic logic [WORD_W-1:0] predict_value(input logic [1:0] op,
                                                        input logic [WORD_W-1:0] seed,
                                                        input logic [WORD_W-1:0] bnd);
        logic [WORD_W-1:0] res;
        logic [WORD_W-1:0] w;
        logic [HALF_W-1:0] b16;
        res = '0;
        case (op)
            OP_SEED: begin
                if (seed != 0) begin
                    gen_word = seed;
                    gen_count = '0;
                    res = seed;
                end else begin
                    res = rule30_advance();
                end
            end
            OP_RAW: begin
                res = rule30_advance();
            end
            OP_MOD: begin
                if (bnd != 0) res = rule30_advance() % bnd;
            end
            default: begin
                b16 = bnd[HALF_W-1:0];
                if (b16 != 0) begin
                    w = rule30_advance();
                    res = {16'h0000, w[HALF_W-1:0] % b16};
                end
            end
        endcase
        return res;
    endfunction

    // one request word; the expectation is logged at the accepting edge
    task automatic send_request(input logic [1:0] op, input logic [WORD_W-1:0] seed,
                                input logic [WORD_W-1:0] bnd);
        @(negedge aclk);
        while (src_idle_on && $urandom_range(99) < 29) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_seed_value <= seed;
        s_bound      <= bnd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_values.push_back(predict_value(op, seed, bnd));
    endtask

    // receiver: random stalls, or a counted hold-off when asked
    initial begin
        forever begin
            @(negedge aclk);
            if (sink_hold > 0) begin
                m_ready <= 1'b0;
                sink_hold = sink_hold - 1;
            end else if (sink_idle_on) begin
                m_ready <= ($urandom_range(99) >= 29);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_values.size() == 0) begin
                $display("%0t: value %08h with nothing expected", $time, m_value);
                err_count++;
            end else begin
                logic [WORD_W-1:0] exp_value;
                exp_value = pending_values.pop_front();
                if (m_value !== exp_value) begin
                    $display("%0t: value mismatch, expected %08h, got %08h",
                             $time, exp_value, m_value);
                    err_count++;
                end
            end
        end
    end

    task automatic test_reset_word();
        send_request(OP_RAW, $urandom, $urandom);
        send_request(OP_RAW, $urandom, $urandom);
        send_request(OP_MOD16, $urandom, 32'hFFFF_FFFF);
    endtask

    task automatic test_reseed();
        send_request(OP_SEED, 32'h0000_0000, $urandom);   // zero seed draws
        send_request(OP_SEED, 32'hFFFF_FFFF, $urandom);
        send_request(OP_RAW, $urandom, $urandom);
        send_request(OP_SEED, 32'h0000_0001, $urandom);
        send_request(OP_RAW, $urandom, $urandom);
        send_request(OP_SEED, 32'h8000_0000, $urandom);
        send_request(OP_RAW, $urandom, $urandom);
    endtask

    task automatic test_ranged();
        send_request(OP_MOD, $urandom, 32'h0000_0000);
        send_request(OP_MOD, $urandom, 32'h0000_0001);
        send_request(OP_MOD, $urandom, 32'hFFFF_FFFF);
        send_request(OP_MOD, $urandom, 32'h8000_0000);
        send_request(OP_MOD, $urandom, 32'h0000_0003);
        send_request(OP_MOD16, $urandom, 32'h0000_0000);
        send_request(OP_MOD16, $urandom, 32'hFFFF_0000);   // upper half ignored
        send_request(OP_MOD16, $urandom, 32'h0000_0001);
        send_request(OP_MOD16, $urandom, 32'h0000_FFFF);
        send_request(OP_MOD16, $urandom, 32'hABCD_0007);
    endtask

    task automatic test_backpressure();
        src_idle_on = 1'b0;
        sink_hold = 300;
        for (int i = 0; i < 12; i++) begin
            send_request(logic'(i[0]) ? OP_RAW : OP_MOD, $urandom, $urandom | 32'd1);
        end
        src_idle_on = 1'b1;
    endtask

    task automatic test_random();
        logic [1:0]        op;
        logic [WORD_W-1:0] seed;
        logic [WORD_W-1:0] bnd;
        for (int n = 0; n < 1500; n++) begin
            src_idle_on  = !(n >= 600 && n < 900);
            sink_idle_on = src_idle_on;
            op = 2'($urandom_range(3));
            case ($urandom_range(7))
                0:       seed = '0;
                1:       seed = $urandom_range(15);
                default: seed = $urandom;
            endcase
            case ($urandom_range(9))
                0:       bnd = '0;
                1:       bnd = $urandom & 32'hFFFF_0000;
                2, 3:    bnd = $urandom;
                default: bnd = $urandom >> $urandom_range(31);
            endcase
            send_request(op, seed, bnd);
        end
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_word();
        test_reseed();
        test_ranged();
        test_backpressure();
        test_random();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_values.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (err_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #6_000_000;
        $display("%0t: timed out with %0d words outstanding", $time, pending_values.size());
        $display("tb: errors");
        $finish;
    end

endmodule
